### hw/rtl/ptd_pkg.sv
package ptd_pkg;

   // Table geometry.
   localparam int NUM_ENTRIES = 8;
   localparam int COUNT_WIDTH = 16;

   // Fixed field widths.
   localparam int PERIOD_W      = 16;
   localparam int ENTRY_FIELD_W = 3;
   localparam int ACTIVE_W      = 4;
   localparam int RELOAD_W      = 8;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 8;

   // Derived widths: an entry index, and a count of entries (0 to NUM_ENTRIES).
   localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int NUM_W = $clog2(NUM_ENTRIES + 1);

   // Register reset values.
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;
   localparam logic [RELOAD_W-1:0] RELOAD_RESET = 8'd9;

   typedef enum logic {
      CMD_TICK       = 1'b0,
      CMD_SET_PERIOD = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_ENTRIES = 1'b0,
      CSR_IDLE_RELOAD    = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SEARCH
   } state_type;

   // Controls broadcast from the sequencer to every cell.
   typedef struct packed {
      logic                inc;     // count up all active entries
      logic                wr;      // period write to the selected entry
      logic                load;    // place the search token at the start entry
      logic                search;  // token check and hand-off
      logic [PERIOD_W-1:0] period;  // period data for a write
   } cell_ctrl_type;

   // Entry index to the fixed-width result field.
   function automatic logic [ENTRY_FIELD_W-1:0] to_entry_field(input logic [IDX_W-1:0] pos);
      logic [31:0] wide;
      wide = 32'(pos);
      return wide[ENTRY_FIELD_W-1:0];
   endfunction

endpackage

### hw/rtl/ptd_cell.sv
module ptd_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ptd_pkg::cell_ctrl_type ctrl,
   input  logic                   is_active,
   input  logic                   wr_sel,
   input  logic                   is_start,
   input  logic                   token_in,
   output logic                   token_out,
   output logic                   due
);
   import ptd_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [PERIOD_W-1:0]    period_ff, period_in;
   logic                   tok_ff, tok_in;

   // The entry is due once its elapsed count has reached its period.
   assign due       = CMP_W'(count_ff) >= CMP_W'(period_ff);
   assign token_out = tok_ff;

   // Saturating count, cleared when the token finds this entry due.
   always_comb begin
      count_in = count_ff;
      if (ctrl.inc && is_active && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end
      if (ctrl.search && tok_ff && due) begin
         count_in = '0;
      end
   end

   assign period_in = (ctrl.wr && wr_sel) ? ctrl.period : period_ff;

   // The token is placed at the start entry, then moves one cell per cycle while the search runs.
   always_comb begin
      tok_in = tok_ff;
      if (ctrl.load) begin
         tok_in = is_start;
      end else if (ctrl.search) begin
         tok_in = token_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         period_ff <= '0;
         tok_ff    <= 1'b0;
      end else begin
         count_ff  <= count_in;
         period_ff <= period_in;
         tok_ff    <= tok_in;
      end
   end

endmodule

### hw/rtl/ptd_seq.sv
module ptd_seq (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [ptd_pkg::PERIOD_W-1:0]         req_period_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_fired,
   output logic [ptd_pkg::ENTRY_FIELD_W-1:0]    rsp_fired_entry,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ptd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ptd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 hit,
   output ptd_pkg::cell_ctrl_type               ctrl,
   output logic [ptd_pkg::NUM_W-1:0]            n_eff,
   output logic [ptd_pkg::NUM_W-1:0]            start_pos
);
   import ptd_pkg::*;

   state_type                state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_fired_ff, rsp_fired_in;
   logic [ENTRY_FIELD_W-1:0] rsp_entry_ff, rsp_entry_in;
   logic [ACTIVE_W-1:0]      active_ff, active_in;
   logic [RELOAD_W-1:0]      reload_ff, reload_in;
   logic [RELOAD_W-1:0]      countdown_ff, countdown_in;
   logic [IDX_W-1:0]         last_ff, last_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic [IDX_W-1:0]         steps_ff, steps_in;
   logic [NUM_W-1:0]         start_ff, start_in;
   logic                     accept;
   logic                     pos_at_end;

   // Active count, limited to the table size.
   always_comb begin
      if (32'(active_ff) > NUM_ENTRIES) begin
         n_eff = NUM_W'(NUM_ENTRIES);
      end else begin
         n_eff = NUM_W'(active_ff);
      end
   end

   assign csr_ready = 1'b1;
   assign start_pos = start_ff;

   // A new item is taken only while idle and with the result slot free or draining.
   assign req_stall = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;

   assign pos_at_end = (NUM_W'(pos_ff) == (n_eff - NUM_W'(1)));

   // Next state, register updates and cell controls.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_fired_in = rsp_fired_ff;
      rsp_entry_in = rsp_entry_ff;
      active_in    = active_ff;
      reload_in    = reload_ff;
      countdown_in = countdown_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      steps_in     = steps_ff;
      start_in     = start_ff;
      ctrl         = '0;
      ctrl.period  = req_period_value;

      if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            CSR_ACTIVE_ENTRIES: active_in = csr_wdata[ACTIVE_W-1:0];
            CSR_IDLE_RELOAD:    reload_in = csr_wdata[RELOAD_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_SET_PERIOD) begin
                  ctrl.wr      = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_fired_in = 1'b0;
                  rsp_entry_in = '0;
               end else if (n_eff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_fired_in = 1'b0;
                  rsp_entry_in = '0;
               end else begin
                  ctrl.inc = 1'b1;
                  if (countdown_ff != '0) begin
                     countdown_in = countdown_ff - RELOAD_W'(1);
                     rsp_valid_in = 1'b1;
                     rsp_fired_in = 1'b0;
                     rsp_entry_in = '0;
                  end else begin
                     start_in = NUM_W'(last_ff) + NUM_W'(1);
                     state_in = ST_REDUCE;
                  end
               end
            end
         end
         ST_REDUCE: begin
            // Bring the start entry below the active count by repeated subtraction.
            if (start_ff >= n_eff) begin
               start_in = start_ff - n_eff;
            end else begin
               ctrl.load = 1'b1;
               pos_in    = start_ff[IDX_W-1:0];
               steps_in  = '0;
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            ctrl.search = 1'b1;
            if (hit) begin
               rsp_valid_in = 1'b1;
               rsp_fired_in = 1'b1;
               rsp_entry_in = to_entry_field(pos_ff);
               last_in      = pos_ff;
               countdown_in = reload_ff;
               state_in     = ST_IDLE;
            end else if (NUM_W'(steps_ff) == (n_eff - NUM_W'(1))) begin
               rsp_valid_in = 1'b1;
               rsp_fired_in = 1'b0;
               rsp_entry_in = '0;
               last_in      = pos_ff;
               state_in     = ST_IDLE;
            end else begin
               pos_in   = pos_at_end ? '0 : pos_ff + IDX_W'(1);
               steps_in = steps_ff + IDX_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= ACTIVE_RESET;
         reload_ff    <= RELOAD_RESET;
         countdown_ff <= '0;
         last_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         reload_ff    <= reload_in;
         countdown_ff <= countdown_in;
         last_ff      <= last_in;
      end
   end

   // Search position and result payload.
   always_ff @(posedge clock) begin
      rsp_fired_ff <= rsp_fired_in;
      rsp_entry_ff <= rsp_entry_in;
      pos_ff       <= pos_in;
      steps_ff     <= steps_in;
      start_ff     <= start_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fired       = rsp_fired_ff;
   assign rsp_fired_entry = rsp_entry_ff;

`ifndef SYNTHESIS
   a_slot_empty_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result slot occupied during a search");

   a_search_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> ((NUM_W'(pos_ff) < n_eff) && (NUM_W'(steps_ff) < n_eff)))
      else $error("search position or step count beyond the active entries");

   a_hit_reports_fire: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SEARCH) && hit) |=> (rsp_valid_ff && rsp_fired_ff))
      else $error("token hit did not produce a firing result");
`endif

endmodule

### hw/rtl/periodic_task_dispatcher.sv
// Periodic task dispatcher: one result transfer per request. A period write, a tick
// with zero active entries, and a tick while the idle countdown is running each
// place their result in the output register in the cycle after they are accepted.
// A tick with the countdown at zero starts a round-robin search: the sequencer first
// reduces (last searched entry + 1) modulo the active count by repeated subtraction
// of the active count, then a token walks the row of entry cells one cell per cycle,
// checking each active entry at most once until it finds one that is due.
// Results sit in an output register; the next request is taken while the sequencer
// is idle and that register is empty or being taken. Configuration writes are
// always ready.
module periodic_task_dispatcher (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic [ptd_pkg::ENTRY_FIELD_W-1:0]  req_entry_index,
   input  logic [ptd_pkg::PERIOD_W-1:0]       req_period_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_fired,
   output logic [ptd_pkg::ENTRY_FIELD_W-1:0]  rsp_fired_entry,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ptd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ptd_pkg::*;

   cell_ctrl_type          ctrl;
   logic [NUM_W-1:0]       n_eff;
   logic [NUM_W-1:0]       start_pos;
   logic [NUM_ENTRIES-1:0] tok;
   logic [NUM_ENTRIES-1:0] due;
   logic [NUM_ENTRIES-1:0] last;
   logic [NUM_ENTRIES-1:0] active;
   logic                   hit;

   ptd_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_period_value (req_period_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fired        (rsp_fired),
      .rsp_fired_entry  (rsp_fired_entry),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .hit              (hit),
      .ctrl             (ctrl),
      .n_eff            (n_eff),
      .start_pos        (start_pos)
   );

   // Row of entry cells; the token wraps from the last active cell to cell zero.
   for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cell
      localparam logic [NUM_W-1:0] K = NUM_W'(k);
      logic tok_in;

      assign active[k] = K < n_eff;
      assign last[k]   = K == (n_eff - NUM_W'(1));

      if (k == 0) begin : g_head
         assign tok_in = |(tok & last);
      end else begin : g_body
         assign tok_in = tok[k-1] && !last[k-1];
      end

      ptd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .is_active (active[k]),
         .wr_sel    (int'(req_entry_index) == k),
         .is_start  (start_pos == K),
         .token_in  (tok_in),
         .token_out (tok[k]),
         .due       (due[k])
      );
   end

   // The cell holding the token is checked against its period.
   assign hit = |(tok & due);

`ifndef SYNTHESIS
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      ctrl.search |-> $onehot(tok))
      else $error("search token lost or duplicated");

   a_token_in_active: assert property (@(posedge clock) disable iff (reset)
      ctrl.search |-> ((tok & ~active) == '0))
      else $error("search token outside the active entries");
`endif

endmodule
